/* hw/rtl/spnc_pkg.sv */
// Package: cipher constants, s-box, permutation and round helpers.
`timescale 1ns / 1ps
`default_nettype none
package spnc_pkg;

   localparam int ROUNDS = 8;
   localparam int BLK_BYTES = 16;
   localparam int KEY_BYTES = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_W = 5;
   // wide enough for the settle counter's reset and reload value ROUNDS-1
   localparam int SETTLE_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   typedef logic [7:0] byte_type;
   typedef byte_type [BLK_BYTES-1:0] block_type;
   typedef byte_type [KEY_BYTES-1:0] rkey_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0  = 3'd0,
      CSR_KEY1  = 3'd1,
      CSR_KEY2  = 3'd2,
      CSR_KEY3  = 3'd3,
      CSR_NONCE = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_ECB = 1'b0,
      OP_CTR = 1'b1
   } op_type;

   // per-item side info traveling alongside the block
   typedef struct packed {
      logic             ctr;
      logic [63:0]      data_low;
      logic [63:0]      data_high;
      logic [CNT_W-1:0] byte_count;
   } side_type;

   localparam logic [3:0] PERM [BLK_BYTES] = '{
      4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
      4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3};

   localparam byte_type SBOX [256] = '{
      8'h2d,8'h7f,8'hae,8'h18,8'h5b,8'hc3,8'h41,8'h96,8'he2,8'h0a,8'hf4,8'h67,8'h3c,8'hb9,8'h84,8'h1e,
      8'h52,8'hd6,8'h9f,8'h20,8'h6e,8'ha7,8'h33,8'hc8,8'h14,8'hfb,8'h45,8'h8d,8'h71,8'hba,8'h06,8'he9,
      8'h99,8'h5a,8'hdc,8'h2b,8'h78,8'hc1,8'h4f,8'ha3,8'h15,8'he6,8'h60,8'hb2,8'h8c,8'h37,8'hfd,8'h0b,
      8'h54,8'hd9,8'ha1,8'h2e,8'h72,8'hbf,8'h46,8'hc5,8'h19,8'hea,8'h63,8'h9d,8'h80,8'h38,8'hf7,8'h1c,
      8'hb5,8'h6a,8'hde,8'h24,8'h91,8'hcf,8'h58,8'ha6,8'h12,8'he8,8'h7d,8'hbb,8'h30,8'h4a,8'hc9,8'h05,
      8'h97,8'h5e,8'hd2,8'h2c,8'h76,8'hb8,8'h43,8'hcd,8'h1a,8'hec,8'h61,8'h9a,8'h85,8'h39,8'hf1,8'h0d,
      8'hb3,8'h68,8'hdd,8'h22,8'h93,8'hc6,8'h5c,8'ha9,8'h17,8'hef,8'h7b,8'hb4,8'h3e,8'h48,8'hca,8'h01,
      8'h95,8'h5d,8'hd1,8'h29,8'h74,8'hbe,8'h42,8'hcc,8'h1b,8'hed,8'h66,8'h9c,8'h81,8'h3a,8'hf6,8'h0c,
      8'hb6,8'h69,8'hdf,8'h23,8'h92,8'hc7,8'h57,8'ha8,8'h16,8'heb,8'h7c,8'hb7,8'h31,8'h49,8'hce,8'h04,
      8'h98,8'h59,8'hd3,8'h2a,8'h77,8'hbc,8'h44,8'hcb,8'h1d,8'hee,8'h62,8'h9b,8'h86,8'h3b,8'hf5,8'h0e,
      8'hb1,8'h6c,8'hdb,8'h27,8'h94,8'hc4,8'h56,8'haa,8'h13,8'he7,8'h7e,8'hb0,8'h3d,8'h4c,8'hc2,8'h08,
      8'h9e,8'h55,8'hd7,8'h21,8'h79,8'hbd,8'h40,8'hc0,8'h11,8'he5,8'h6b,8'h9f,8'h88,8'h34,8'hf3,8'h0f,
      8'haf,8'h6d,8'hd8,8'h25,8'h90,8'hd0,8'h53,8'hab,8'h10,8'he4,8'h75,8'hb9,8'h32,8'h4b,8'hd4,8'h02,
      8'h96,8'h51,8'hd5,8'h28,8'h73,8'hbb,8'h47,8'hce,8'h1f,8'hef,8'h64,8'h98,8'h83,8'h3f,8'hf2,8'h09,
      8'hb4,8'h65,8'hda,8'h26,8'h8f,8'hc5,8'h50,8'hac,8'h14,8'he3,8'h70,8'hbc,8'h35,8'h4d,8'hd6,8'h03,
      8'h8e,8'h5f,8'hd0,8'h2f,8'h7a,8'hbf,8'h4e,8'hcf,8'h1e,8'he1,8'h6f,8'ha0,8'h89,8'h36,8'hf8,8'h00};

   function automatic byte_type rotl8(input byte_type v, input int s);
      return byte_type'((v << s) | (v >> (8 - s)));
   endfunction

   function automatic byte_type rotr8(input byte_type v, input int s);
      return byte_type'((v >> s) | (v << (8 - s)));
   endfunction

   // next round key from the previous one; r is the round being derived
   function automatic rkey_type next_rkey(input rkey_type p, input int r);
      rkey_type k;
      for (int i = 0; i < KEY_BYTES; i++) begin
         k[i] = rotl8(p[i] ^ p[(i + 1) % KEY_BYTES], 3)
              ^ SBOX[p[(i + KEY_BYTES - 1) % KEY_BYTES]]
              ^ byte_type'((r * 17 + i * 23) & 8'hFF);
      end
      return k;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/spn_block_cipher_ctr_top.sv */
// Top level: key and nonce registers, key schedule chain, round chain and output mask.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | opcode, data, counter, byte count
//   rsp     | out | rsp_valid/rsp_ready | result_low, result_high
//   csr     | in  | csr_write_enable    | csr_index, csr_write_data
//
// One item per cycle unless rsp stalls or the key schedule is settling.
// The key schedule is a chain of ROUNDS-1 registered cells; after reset or a
// key write it settles, and no item is taken until the settle counter is zero.
// Synchronous active-high reset clears valid bits, keys and nonce, reloads the settle counter.
// A stalled rsp freezes the round chain; req_ready then follows rsp_ready while settled.
`timescale 1ns / 1ps
`default_nettype none
module spn_block_cipher_ctr_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_opcode,
   input  wire [63:0]                       req_data_low,
   input  wire [63:0]                       req_data_high,
   input  wire [63:0]                       req_block_counter,
   input  wire [spnc_pkg::CNT_W-1:0]        req_byte_count,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [63:0]                      rsp_result_low,
   output logic [63:0]                      rsp_result_high,
   input  wire                              csr_write_enable,
   input  wire [spnc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [63:0]                       csr_write_data
);
   import spnc_pkg::*;

   logic [63:0] key_ff [4];
   logic [63:0] nonce_ff;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   rkey_type  rk [ROUNDS];
   block_type blk [ROUNDS+1];
   side_type  sd [ROUNDS+1];
   logic      vld [ROUNDS+1];
   logic      advance;
   logic      key_wr;

   assign key_wr = csr_write_enable && (csr_index == CSR_KEY0 || csr_index == CSR_KEY1
                   || csr_index == CSR_KEY2 || csr_index == CSR_KEY3);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) key_ff[k] <= '0;
         nonce_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY0:  key_ff[0] <= csr_write_data;
            CSR_KEY1:  key_ff[1] <= csr_write_data;
            CSR_KEY2:  key_ff[2] <= csr_write_data;
            CSR_KEY3:  key_ff[3] <= csr_write_data;
            CSR_NONCE: nonce_ff  <= csr_write_data;
            default:   ;
         endcase
      end
   end

   // wait for the schedule chain to refill after a key change
   always_comb begin
      if (key_wr) settle_in = SETTLE_W'(ROUNDS - 1);
      else if (settle_ff != '0) settle_in = settle_ff - SETTLE_W'(1);
      else settle_in = settle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) settle_ff <= SETTLE_W'(ROUNDS - 1);
      else settle_ff <= settle_in;
   end

   always_comb begin
      for (int i = 0; i < KEY_BYTES; i++) begin
         rk[0][i] = key_ff[i / 8][(i % 8) * 8 +: 8];
      end
   end

   for (genvar r = 1; r < ROUNDS; r++) begin : g_key
      spnc_key_cell u_key (
         .clock     (clock),
         .prev_key  (rk[r-1]),
         .round_idx (4'(r)),
         .rkey      (rk[r])
      );
   end

   assign advance   = !vld[ROUNDS] || rsp_ready;
   assign req_ready = advance && (settle_ff == '0);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         blk[0][i]   = (req_opcode == OP_CTR) ? nonce_ff[i*8 +: 8] : req_data_low[i*8 +: 8];
         blk[0][i+8] = (req_opcode == OP_CTR) ? req_block_counter[i*8 +: 8]
                                             : req_data_high[i*8 +: 8];
      end
      sd[0].ctr        = (req_opcode == OP_CTR);
      sd[0].data_low   = req_data_low;
      sd[0].data_high  = req_data_high;
      sd[0].byte_count = req_byte_count;
      vld[0]           = req_valid && req_ready;
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      spnc_round_cell u_round (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .last_round (r == ROUNDS - 1),
         .in_valid   (vld[r]),
         .in_block   (blk[r]),
         .in_side    (sd[r]),
         .rkey       (rk[r]),
         .out_valid  (vld[r+1]),
         .out_block  (blk[r+1]),
         .out_side   (sd[r+1])
      );
   end

   always_comb begin
      side_type s;
      s = sd[ROUNDS];
      for (int i = 0; i < 8; i++) begin
         if (!s.ctr) begin
            rsp_result_low[i*8 +: 8]  = blk[ROUNDS][i];
            rsp_result_high[i*8 +: 8] = blk[ROUNDS][i+8];
         end else begin
            rsp_result_low[i*8 +: 8]  = (CNT_W'(i) < s.byte_count)
               ? (blk[ROUNDS][i] ^ s.data_low[i*8 +: 8]) : 8'h00;
            rsp_result_high[i*8 +: 8] = (CNT_W'(i + 8) < s.byte_count)
               ? (blk[ROUNDS][i+8] ^ s.data_high[i*8 +: 8]) : 8'h00;
         end
      end
   end

   assign rsp_valid = vld[ROUNDS];

`ifndef SYNTHESIS
   a_no_take_settling: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> !req_ready)
      else $error("item taken while key schedule settles");
   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> !req_ready)
      else $error("req_ready high right after key write");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_result_low))
      else $error("result changed under stall");
   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item taken while chain is frozen");
`endif

endmodule
`default_nettype wire

/* hw/rtl/spnc_key_cell.sv */
// Key schedule cell: holds one round key, refreshed from its upstream neighbor.
`timescale 1ns / 1ps
`default_nettype none
module spnc_key_cell (
   input  wire                       clock,
   input  wire spnc_pkg::rkey_type   prev_key,
   input  wire [3:0]                 round_idx,
   output spnc_pkg::rkey_type        rkey
);
   import spnc_pkg::*;

   rkey_type rkey_ff, rkey_in;

   always_comb begin
      rkey_in = next_rkey(prev_key, int'(round_idx));
   end

   always_ff @(posedge clock) begin
      rkey_ff <= rkey_in;
   end

   assign rkey = rkey_ff;

endmodule
`default_nettype wire

/* hw/rtl/spnc_round_cell.sv */
// Round cell: key xor, s-box, permutation and serial diffusion (skipped in the last round), then a register.
`timescale 1ns / 1ps
`default_nettype none
module spnc_round_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  wire                       last_round,
   input  wire                       in_valid,
   input  wire spnc_pkg::block_type  in_block,
   input  wire spnc_pkg::side_type   in_side,
   input  wire spnc_pkg::rkey_type   rkey,
   output logic                      out_valid,
   output spnc_pkg::block_type       out_block,
   output spnc_pkg::side_type        out_side
);
   import spnc_pkg::*;

   logic      valid_ff;
   block_type block_ff, block_in;
   side_type  side_ff;

   always_comb begin
      block_type s, t, d;
      for (int i = 0; i < BLK_BYTES; i++) begin
         s[i] = SBOX[in_block[i] ^ rkey[i]];
      end
      for (int i = 0; i < BLK_BYTES; i++) begin
         t[i] = s[PERM[i]];
      end
      // in-place diffusion: from byte 1 on, byte i sees the updated byte i-1
      d[0] = rotl8(t[0], 2) ^ rotr8(t[15], 1) ^ t[1];
      for (int i = 1; i < BLK_BYTES - 1; i++) begin
         d[i] = rotl8(t[i], 2) ^ rotr8(d[i-1], 1) ^ t[i+1];
      end
      d[15] = rotl8(t[15], 2) ^ rotr8(d[14], 1) ^ d[0];
      block_in = last_round ? t : d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         block_ff <= block_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire
